>>> hdl/stsd_pkg.sv
// ----------------------------------------------------------------------------
// stsd_pkg
// Shared types and widths for the sphere triangle subdivider.
// ----------------------------------------------------------------------------
package stsd_pkg;

  localparam int COORD_FRAC_BITS = 14;

  // coordinate, edge sum, square and length widths
  localparam int CW  = 16;
  localparam int SW  = CW + 1;
  localparam int SQW = 2 * SW;
  localparam int LW  = SQW + 2;

  // quotient sq * 2^K / len, then integer square root of it
  localparam int K   = 2 * COORD_FRAC_BITS + 2;
  localparam int QW  = K + 1;
  localparam int RW  = COORD_FRAC_BITS + 2;
  localparam int NW  = 2 * RW;

  localparam int FRONT_LAT = 3;
  localparam int NORM_LAT  = QW + RW + 1;
  localparam int PIPE_LAT  = FRONT_LAT + NORM_LAT;

  localparam int NUM_EDGES = 3;
  localparam int NUM_COMPS = 3;

  typedef struct packed {
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } vec_t;

  typedef struct packed {
    vec_t c;
    vec_t b;
    vec_t a;
  } tri_t;

  typedef struct packed {
    tri_t verts;
    logic mesh_end;
  } item_t;

  // which of the four output triangles is shown
  typedef enum logic [1:0] {
    SEL_A_CORNER,
    SEL_B_CORNER,
    SEL_CENTER,
    SEL_C_CORNER
  } tri_sel_e;

  // edge order: a+b, a+c, b+c
  localparam int EDGE_AB = 0;
  localparam int EDGE_AC = 1;
  localparam int EDGE_BC = 2;

endpackage

>>> hdl/stsd_front.sv
// ----------------------------------------------------------------------------
// stsd_front
// Edge sums, component squares and squared lengths, three register stages.
// ----------------------------------------------------------------------------
module stsd_front (
  input  logic                                             clk_i,
  input  logic                                             en_i,
  input  stsd_pkg::tri_t                                   tri_i,
  output logic [2:0][2:0][stsd_pkg::SQW-1:0]               sq_o,
  output logic [2:0][2:0]                                  neg_o,
  output logic [2:0][stsd_pkg::LW-1:0]                     len_o
);
  import stsd_pkg::*;

  logic signed [NUM_EDGES-1:0][NUM_COMPS-1:0][SW-1:0] sum_d, sum_q;
  logic [NUM_EDGES-1:0][NUM_COMPS-1:0][SQW-1:0]       sqa_d, sqa_q, sqb_q;
  logic [NUM_EDGES-1:0][NUM_COMPS-1:0]                nega_d, nega_q, negb_q;
  logic [NUM_EDGES-1:0][LW-1:0]                       len_d, len_q;
  vec_t                                               u [NUM_EDGES];
  vec_t                                               v [NUM_EDGES];

  always_comb begin
    u[EDGE_AB] = tri_i.a;  v[EDGE_AB] = tri_i.b;
    u[EDGE_AC] = tri_i.a;  v[EDGE_AC] = tri_i.c;
    u[EDGE_BC] = tri_i.b;  v[EDGE_BC] = tri_i.c;
    for (int e = 0; e < NUM_EDGES; e++) begin
      sum_d[e][0] = SW'(u[e].x) + SW'(v[e].x);
      sum_d[e][1] = SW'(u[e].y) + SW'(v[e].y);
      sum_d[e][2] = SW'(u[e].z) + SW'(v[e].z);
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      for (int c = 0; c < NUM_COMPS; c++) begin
        sqa_d[e][c]  = SQW'($signed(sum_q[e][c]) * $signed(sum_q[e][c]));
        nega_d[e][c] = sum_q[e][c][SW-1];
      end
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      len_d[e] = LW'(sqa_q[e][0]) + LW'(sqa_q[e][1]) + LW'(sqa_q[e][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= sum_d;
      sqa_q  <= sqa_d;
      nega_q <= nega_d;
      sqb_q  <= sqa_q;
      negb_q <= nega_q;
      len_q  <= len_d;
    end
  end

  assign sq_o  = sqb_q;
  assign neg_o = negb_q;
  assign len_o = len_q;

endmodule

>>> hdl/stsd_norm.sv
// ----------------------------------------------------------------------------
// stsd_norm
// One component lane: restoring divide sq*2^K/len one bit a stage, then a
// restoring square root one bit a stage, then round half up and sign.
// ----------------------------------------------------------------------------
module stsd_norm (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [stsd_pkg::SQW-1:0]    sq_i,
  input  logic [stsd_pkg::LW-1:0]     len_i,
  input  logic                        neg_i,
  output logic [stsd_pkg::CW-1:0]     mid_o
);
  import stsd_pkg::*;

  logic [LW-1:0] div_r_q [QW];
  logic [LW-1:0] div_l_q [QW];
  logic [QW-1:0] div_q_q [QW];
  logic          div_s_q [QW];
  logic          div_z_q [QW];

  logic [NW-1:0] rt_n_q    [RW];
  logic [RW+1:0] rt_rem_q  [RW];
  logic [RW-1:0] rt_root_q [RW];
  logic          rt_s_q    [RW];
  logic          rt_z_q    [RW];

  logic [CW-1:0] mid_q;

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [LW:0]   t;
    logic [LW-1:0] l;
    logic [QW-1:0] qp;
    logic          s, z, ge;

    always_comb begin
      if (i == 0) begin
        t  = {1'b0, LW'(sq_i)};
        l  = len_i;
        qp = '0;
        s  = neg_i;
        z  = (len_i == '0);
      end else begin
        t  = {div_r_q[(i == 0) ? 0 : i-1], 1'b0};
        l  = div_l_q[(i == 0) ? 0 : i-1];
        qp = div_q_q[(i == 0) ? 0 : i-1];
        s  = div_s_q[(i == 0) ? 0 : i-1];
        z  = div_z_q[(i == 0) ? 0 : i-1];
      end
      ge = (t >= {1'b0, l});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_r_q[i] <= ge ? LW'(t - {1'b0, l}) : LW'(t);
        div_l_q[i] <= l;
        div_q_q[i] <= {qp[QW-2:0], ge};
        div_s_q[i] <= s;
        div_z_q[i] <= z;
      end
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_root
    logic [NW-1:0] n;
    logic [RW+1:0] rem, rem_sh, trial;
    logic [RW-1:0] root;
    logic          s, z, ge;

    always_comb begin
      if (j == 0) begin
        n    = NW'(div_q_q[QW-1]);
        rem  = '0;
        root = '0;
        s    = div_s_q[QW-1];
        z    = div_z_q[QW-1];
      end else begin
        n    = rt_n_q[(j == 0) ? 0 : j-1];
        rem  = rt_rem_q[(j == 0) ? 0 : j-1];
        root = rt_root_q[(j == 0) ? 0 : j-1];
        s    = rt_s_q[(j == 0) ? 0 : j-1];
        z    = rt_z_q[(j == 0) ? 0 : j-1];
      end
      rem_sh = {rem[RW-1:0], n[NW-1 -: 2]};
      trial  = {root, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_n_q[j]    <= n << 2;
        rt_rem_q[j]  <= ge ? (rem_sh - trial) : rem_sh;
        rt_root_q[j] <= {root[RW-2:0], ge};
        rt_s_q[j]    <= s;
        rt_z_q[j]    <= z;
      end
    end
  end

  // round: largest m with 2m-1 <= floor root
  logic [RW:0]        mag;
  logic signed [RW:0] val;

  always_comb begin
    mag = ((RW+1)'(rt_root_q[RW-1]) + (RW+1)'(1)) >> 1;
    val = rt_s_q[RW-1] ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= rt_z_q[RW-1] ? '0 : CW'(val);
    end
  end

  assign mid_o = mid_q;

endmodule

>>> hdl/stsd_emit.sv
// ----------------------------------------------------------------------------
// stsd_emit
// Output stage: holds one subdivided triangle and sends its four children.
// ----------------------------------------------------------------------------
module stsd_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  stsd_pkg::item_t       item_i,
  input  stsd_pkg::vec_t [2:0]  mid_i,
  input  logic                  tready_i,
  output logic                  tvalid_o,
  output stsd_pkg::tri_t        tdata_o,
  output logic                  tlast_o,
  output logic                  tuser_o,
  output logic                  free_o
);
  import stsd_pkg::*;

  tri_sel_e     sel_d, sel_q;
  logic         vld_d, vld_q;
  item_t        item_q;
  vec_t [2:0]   mid_q;

  assign free_o = !vld_q || (sel_q == SEL_C_CORNER && tready_i);

  always_comb begin
    sel_d = sel_q;
    vld_d = vld_q;
    if (load_i) begin
      sel_d = SEL_A_CORNER;
      vld_d = 1'b1;
    end else if (vld_q && tready_i) begin
      case (sel_q)
        SEL_A_CORNER: sel_d = SEL_B_CORNER;
        SEL_B_CORNER: sel_d = SEL_CENTER;
        SEL_CENTER:   sel_d = SEL_C_CORNER;
        default: begin
          sel_d = SEL_A_CORNER;
          vld_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SEL_A_CORNER;
      vld_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
      mid_q  <= mid_i;
    end
  end

  always_comb begin
    tdata_o = '0;
    tlast_o = 1'b0;
    tuser_o = 1'b0;
    case (sel_q)
      SEL_A_CORNER: begin
        tdata_o.a = item_q.verts.a;
        tdata_o.b = mid_q[EDGE_AB];
        tdata_o.c = mid_q[EDGE_AC];
      end
      SEL_B_CORNER: begin
        tdata_o.a = mid_q[EDGE_AB];
        tdata_o.b = item_q.verts.b;
        tdata_o.c = mid_q[EDGE_BC];
      end
      SEL_CENTER: begin
        tdata_o.a = mid_q[EDGE_AB];
        tdata_o.b = mid_q[EDGE_BC];
        tdata_o.c = mid_q[EDGE_AC];
      end
      default: begin
        tdata_o.a = mid_q[EDGE_AC];
        tdata_o.b = mid_q[EDGE_BC];
        tdata_o.c = item_q.verts.c;
        tlast_o   = 1'b1;
        tuser_o   = item_q.mesh_end;
      end
    endcase
  end

  assign tvalid_o = vld_q;

endmodule

>>> hdl/sphere_triangle_subdivider_core.sv
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider_core
// Splits a unit-sphere triangle into four, projecting edge midpoints.
// Stages: an accepted word passes 3 front, 31 divide, 16 root, 1 rounding and 1
//   output stage before the first of its output words can be taken.
// Throughput: the output stage sends four output words per input word, so a
//   full pipeline holds off input; the pipeline takes one word a cycle when not stalled.
// Reset: clears valid bits and the output stage; no data path reset.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [143:0] s_axis_tdata_i,  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic         s_axis_tlast_i,  // mesh_end_in
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [143:0] m_axis_tdata_o,  // p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z
  output logic         m_axis_tlast_o,  // last_of_run
  output logic         m_axis_tuser_o   // mesh_end_out
);
  import stsd_pkg::*;

  logic                   adv, emit_free, load;
  logic [PIPE_LAT-1:0]    vld_q;
  item_t                  item_q [PIPE_LAT];
  item_t                  item_in;
  tri_t                   out_tri;

  logic [2:0][2:0][SQW-1:0] sq;
  logic [2:0][2:0]          neg;
  logic [2:0][LW-1:0]       len;
  vec_t [2:0]               mid;

  assign item_in.verts    = tri_t'(s_axis_tdata_i);
  assign item_in.mesh_end = s_axis_tlast_i;

  // advance the whole pipeline when its last stage is empty or drains
  assign adv             = !vld_q[PIPE_LAT-1] || emit_free;
  assign load            = vld_q[PIPE_LAT-1] && emit_free;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q[0] <= item_in;
      for (int i = 1; i < PIPE_LAT; i++) begin
        item_q[i] <= item_q[i-1];
      end
    end
  end

  stsd_front u_front (
    .clk_i (clk_i),
    .en_i  (adv),
    .tri_i (item_in.verts),
    .sq_o  (sq),
    .neg_o (neg),
    .len_o (len)
  );

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
    logic [NUM_COMPS-1:0][CW-1:0] comp;

    for (genvar c = 0; c < NUM_COMPS; c++) begin : g_comp
      stsd_norm u_norm (
        .clk_i (clk_i),
        .en_i  (adv),
        .sq_i  (sq[e][c]),
        .len_i (len[e]),
        .neg_i (neg[e][c]),
        .mid_o (comp[c])
      );
    end

    assign mid[e].x = comp[0];
    assign mid[e].y = comp[1];
    assign mid[e].z = comp[2];
  end

  stsd_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .item_i   (item_q[PIPE_LAT-1]),
    .mid_i    (mid),
    .tready_i (m_axis_tready_i),
    .tvalid_o (m_axis_tvalid_o),
    .tdata_o  (out_tri),
    .tlast_o  (m_axis_tlast_o),
    .tuser_o  (m_axis_tuser_o),
    .free_o   (emit_free)
  );

  assign m_axis_tdata_o = out_tri;

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("mesh end flag without run end");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[PIPE_LAT-1] |-> s_axis_tready_o)
    else $error("input stalled with empty pipeline tail");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted word lost at pipeline entry");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid_o && !m_axis_tlast_o)
    else $error("loaded triangle not shown from its first child");

endmodule

>>> tb/sv/sphere_triangle_subdivider_core_tb.sv
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider_core_tb
// Self-checking bench for the sphere triangle subdivider: drives triangles on
// the input stream, computes the four expected output triangles of each one
// with an exact rounded normalization, and compares them word by word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_triangle_subdivider_core_tb;
  import stsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = PIPE_LAT + 20;
  localparam int NUM_RANDOM     = 250;
  localparam int NUM_DIRECTED   = 16;

  typedef struct packed {
    vec_t p;
    vec_t q;
    vec_t r;
    logic last;
    logic mesh_end;
  } out_tri_t;

  // directed row: expected words only for rows where they are obvious
  typedef struct {
    tri_t     verts;
    logic     mesh_end;
    bit       has_fixed;
    out_tri_t fixed_first;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic         m_axis_tuser_o;

  out_tri_t expected_tris[$];
  int       fail_count = 0;
  int       idle_cycles = 0;
  int       tris_sent = 0;
  int       tris_checked = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  always #2 clk_i = ~clk_i;

  sphere_triangle_subdivider_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // largest m with (2m-1)^2 * len2 <= t^2 * 2^(2F+2): round(t * 2^F / sqrt(len2))
  function automatic logic signed [CW-1:0] project_comp(int s, longint unsigned len2);
    longint unsigned t, lo, hi, mid, d;
    logic [127:0] lhs, rhs;
    if (len2 == 0) return '0;
    t   = (s < 0) ? -s : s;
    rhs = 128'(t * t) << (2 * COORD_FRAC_BITS + 2);
    lo  = 0;
    hi  = 64'd1 << COORD_FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      d   = 2 * mid - 1;
      lhs = 128'(d * d) * 128'(len2);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (s < 0) ? CW'(-lo) : CW'(lo);
  endfunction

  function automatic vec_t sphere_midpoint(vec_t u, vec_t v);
    int s[3];
    longint unsigned len2;
    vec_t m;
    s[0] = int'(u.x) + int'(v.x);
    s[1] = int'(u.y) + int'(v.y);
    s[2] = int'(u.z) + int'(v.z);
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += longint'(s[i]) * longint'(s[i]);
    m.x = project_comp(s[0], len2);
    m.y = project_comp(s[1], len2);
    m.z = project_comp(s[2], len2);
    return m;
  endfunction

  function automatic out_tri_t make_tri(vec_t p, vec_t q, vec_t r, logic last,
                                        logic mesh_end);
    out_tri_t o;
    o.p = p; o.q = q; o.r = r; o.last = last; o.mesh_end = mesh_end;
    return o;
  endfunction

  task automatic queue_subdivision(tri_t t, logic mesh_end);
    vec_t mab, mac, mbc;
    mab = sphere_midpoint(t.a, t.b);
    mac = sphere_midpoint(t.a, t.c);
    mbc = sphere_midpoint(t.b, t.c);
    expected_tris.push_back(make_tri(t.a, mab, mac, 1'b0, 1'b0));
    expected_tris.push_back(make_tri(mab, t.b, mbc, 1'b0, 1'b0));
    expected_tris.push_back(make_tri(mab, mbc, mac, 1'b0, 1'b0));
    expected_tris.push_back(make_tri(mac, mbc, t.c, 1'b1, mesh_end));
  endtask

  function automatic vec_t mk_vec(int x, int y, int z);
    vec_t v;
    v.x = CW'(x); v.y = CW'(y); v.z = CW'(z);
    return v;
  endfunction

  function automatic tri_t mk_tri(vec_t a, vec_t b, vec_t c);
    tri_t t;
    t.a = a; t.b = b; t.c = c;
    return t;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 65535) - 32768;   // any 16-bit code
      1:       return ($urandom_range(0, 1) ? 16384 : -16384);
      2:       return $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  function automatic vec_t rand_vec();
    return mk_vec(rand_coord(), rand_coord(), rand_coord());
  endfunction

  // send one word; expectations are queued at acceptance
  task automatic send_tri(tri_t t, logic mesh_end);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {t.c.z, t.c.y, t.c.x, t.b.z, t.b.y, t.b.x, t.a.z, t.a.y, t.a.x};
    s_axis_tlast_i  <= mesh_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    queue_subdivision(t, mesh_end);
    tris_sent++;
  endtask

  // drop valid after the last word of a burst
  task automatic idle_input();
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic set_phase(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  task automatic check_field(string name, logic signed [CW-1:0] want_v,
                             logic signed [CW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s exp %0d got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // receiver: random stall, check accepted words against the oldest expectation
  always @(posedge clk_i) begin
    out_tri_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.p.x = m_axis_tdata_o[15:0];    got.p.y = m_axis_tdata_o[31:16];
        got.p.z = m_axis_tdata_o[47:32];   got.q.x = m_axis_tdata_o[63:48];
        got.q.y = m_axis_tdata_o[79:64];   got.q.z = m_axis_tdata_o[95:80];
        got.r.x = m_axis_tdata_o[111:96];  got.r.y = m_axis_tdata_o[127:112];
        got.r.z = m_axis_tdata_o[143:128];
        got.last = m_axis_tlast_o;
        got.mesh_end = m_axis_tuser_o;
        if (expected_tris.size() == 0) begin
          $error("unexpected output word %h", m_axis_tdata_o);
          fail_count++;
        end else begin
          want = expected_tris.pop_front();
          tris_checked++;
          check_field("p_x", want.p.x, got.p.x);
          check_field("p_y", want.p.y, got.p.y);
          check_field("p_z", want.p.z, got.p.z);
          check_field("q_x", want.q.x, got.q.x);
          check_field("q_y", want.q.y, got.q.y);
          check_field("q_z", want.q.z, got.q.z);
          check_field("r_x", want.r.x, got.r.x);
          check_field("r_y", want.r.y, got.r.y);
          check_field("r_z", want.r.z, got.r.z);
          if (got.last !== want.last) begin
            $error("last_of_run exp %0d got %0d", want.last, got.last); fail_count++;
          end
          if (got.mesh_end !== want.mesh_end) begin
            $error("mesh_end_out exp %0d got %0d", want.mesh_end, got.mesh_end); fail_count++;
          end
        end
      end
      m_axis_tready_i <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // watchdog: count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d words still expected", expected_tris.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[NUM_DIRECTED];
    vec_t one_x, one_y, one_z, neg_x, zero_v, maxp, maxn;
    tri_t t;
    int waited;

    one_x  = mk_vec(16384, 0, 0);
    one_y  = mk_vec(0, 16384, 0);
    one_z  = mk_vec(0, 0, 16384);
    neg_x  = mk_vec(-16384, 0, 0);
    zero_v = mk_vec(0, 0, 0);
    maxp   = mk_vec(32767, 32767, 32767);
    maxn   = mk_vec(-32768, -32768, -32768);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      rows[i].has_fixed = 1'b0;
      rows[i].mesh_end = 1'b0;
    end
    // octant face: known midpoint 0.7071 -> 11585
    rows[0].verts = mk_tri(one_x, one_y, one_z);
    rows[0].has_fixed = 1'b1;
    rows[0].fixed_first = make_tri(one_x, mk_vec(11585, 11585, 0), mk_vec(11585, 0, 11585),
                                   1'b0, 1'b0);
    // antipodal a and b: zero-length sum gives the zero vector
    rows[1].verts = mk_tri(one_x, neg_x, one_y);
    rows[1].has_fixed = 1'b1;
    rows[1].fixed_first = make_tri(one_x, zero_v, mk_vec(11585, 11585, 0), 1'b0, 1'b0);
    // all-zero triangle, end of mesh
    rows[2].verts = mk_tri(zero_v, zero_v, zero_v);
    rows[2].mesh_end = 1'b1;
    rows[2].has_fixed = 1'b1;
    rows[2].fixed_first = make_tri(zero_v, zero_v, zero_v, 1'b0, 1'b0);
    // coincident corners project onto themselves
    rows[3].verts = mk_tri(one_z, one_z, one_z);
    rows[3].has_fixed = 1'b1;
    rows[3].fixed_first = make_tri(one_z, one_z, one_z, 1'b0, 1'b0);
    rows[4].verts = mk_tri(maxp, maxn, maxp);                  // out-of-range codes
    rows[5].verts = mk_tri(maxn, maxn, maxp);
    rows[5].mesh_end = 1'b1;
    rows[6].verts = mk_tri(mk_vec(-16384, -16384, -16384), one_y, neg_x);
    rows[7].verts = mk_tri(mk_vec(1, 0, 0), mk_vec(0, 1, 0), mk_vec(0, 0, -1)); // tiny
    rows[8].verts = mk_tri(mk_vec(-1, -1, -1), mk_vec(1, 1, 1), mk_vec(1, -1, 0));
    rows[9].verts = mk_tri(mk_vec(16383, -16383, 1), mk_vec(-16383, 16383, 1), one_x);
    rows[10].verts = mk_tri(mk_vec(-21846, 21845, -1), mk_vec(5461, -5462, 255), one_y);
    rows[11].verts = mk_tri(mk_vec(9459, 9459, 9459), mk_vec(-9459, 9459, 9459), one_z);
    rows[12].verts = mk_tri(maxp, zero_v, maxn);
    rows[13].verts = mk_tri(mk_vec(-32768, 32767, 0), mk_vec(-32768, 32767, 0), zero_v);
    rows[14].verts = mk_tri(mk_vec(3, 4, 0), mk_vec(-3, 4, 0), mk_vec(0, -5, 12));
    rows[15].verts = mk_tri(mk_vec(-1, -16384, 16384), mk_vec(1, 16384, -16384), maxp);
    rows[15].mesh_end = 1'b1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, checked against the fixed words where given
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_tri(rows[i].verts, rows[i].mesh_end);
      if (rows[i].has_fixed) begin
        out_tri_t predicted;
        predicted = expected_tris[expected_tris.size() - 4];
        if (predicted !== rows[i].fixed_first) begin
          $error("directed row %0d: fixed word %h, predicted %h", i,
                 rows[i].fixed_first, predicted);
          fail_count++;
        end
      end
    end
    idle_input();

    // hold off until every expected word has come out
    while (expected_tris.size() != 0) @(posedge clk_i);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 40 == 0) set_phase(i / 40);
      case ($urandom_range(0, 5))
        0: t = mk_tri(rand_vec(), rand_vec(), rand_vec());
        1: begin                            // shared or opposite corners
          t.a = rand_vec();
          t.b = $urandom_range(0, 1) ? t.a : mk_vec(-t.a.x, -t.a.y, -t.a.z);
          t.c = rand_vec();
        end
        default: begin                      // results fed back in as a next level
          if (i > 0 && $urandom_range(0, 1))
            t = mk_tri(expected_tris.size() ? expected_tris[$].p : rand_vec(),
                       expected_tris.size() ? expected_tris[$].q : rand_vec(),
                       expected_tris.size() ? expected_tris[$].r : rand_vec());
          else
            t = mk_tri(rand_vec(), rand_vec(), rand_vec());
        end
      endcase
      send_tri(t, $urandom_range(0, 3) == 0);
    end
    idle_input();

    while (expected_tris.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end

    $display("Sent %0d triangles, checked %0d output triangles over four idle/stall mixes,",
             tris_sent, tris_checked);
    $display("including zero-length edges, out-of-range codes and fed-back levels.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
